// ----- hdl/lse_pkg.sv -----
`timescale 1ns / 1ps

package lse_pkg;

   // Fixed field widths of the request and response beats
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;
   localparam int DIST_W   = 8;
   localparam int COUNT_W  = 9;

   // Request operations
   typedef enum logic [MODE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_SEARCH = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TOP_LOAD,
      S_READ,
      S_SCAN,
      S_DONE
   } state_type;

   // Finished-operation status from the sequencer to the response stage
   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [DIST_W-1:0]   match_distance;
   } seq_result_type;

endpackage

// ----- hdl/lse_req_if.sv -----
`timescale 1ns / 1ps

interface lse_req_if;
   logic                               valid;
   logic                               ready;
   logic [lse_pkg::MODE_W-1:0]         mode;
   logic signed [lse_pkg::VALUE_W-1:0] value;
   logic [lse_pkg::POS_W-1:0]          position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// ----- hdl/lse_rsp_if.sv -----
`timescale 1ns / 1ps

interface lse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lse_pkg::STATUS_W-1:0]        status;
   logic signed [lse_pkg::VALUE_W-1:0]  data;
   logic [lse_pkg::DIST_W-1:0]          match_distance;
   logic [lse_pkg::COUNT_W-1:0]         count;
   logic                                is_empty;
   logic signed [lse_pkg::VALUE_W-1:0]  top_value;

   modport source (output valid, output status, output data, output match_distance,
                   output count, output is_empty, output top_value, input ready);
   modport sink   (input valid, input status, input data, input match_distance,
                   input count, input is_empty, input top_value, output ready);
endinterface

// ----- hdl/lse_mem.sv -----
`timescale 1ns / 1ps

module lse_mem #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lse_seq.sv -----
`timescale 1ns / 1ps

module lse_seq #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 8,
   parameter int CNT_W      = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lse_pkg::op_type             req_mode,
   input  logic [DATA_WIDTH-1:0]       req_value,
   input  logic [lse_pkg::POS_W-1:0]   req_position,
   // result side
   input  logic                        out_free,
   output lse_pkg::seq_result_type     result,
   output logic [DATA_WIDTH-1:0]       result_data,
   output logic [CNT_W-1:0]            count,
   output logic [DATA_WIDTH-1:0]       top_entry,
   // entry memory
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [DATA_WIDTH-1:0]       wr_data,
   output logic                        rd_en,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [DATA_WIDTH-1:0]       rd_data
);

   localparam int CMP_W = (CNT_W > lse_pkg::POS_W) ? CNT_W : lse_pkg::POS_W;

   lse_pkg::state_type  state_ff, state_in;
   lse_pkg::op_type     mode_ff, mode_in;
   lse_pkg::status_type status_ff, status_in;
   logic [DATA_WIDTH-1:0]     val_ff, val_in;
   logic [lse_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [DATA_WIDTH-1:0]     top_ff, top_in;
   logic [DATA_WIDTH-1:0]     data_ff, data_in;
   logic [ADDR_W-1:0]         dist_ff, dist_in;
   logic [ADDR_W-1:0]         scan_addr_ff, scan_addr_in;

   logic             accept;
   logic             is_full;
   logic             past_count;
   logic             hit;
   logic [CMP_W-1:0] read_at_addr;

   assign accept       = req_valid && (state_ff == lse_pkg::S_IDLE);
   assign is_full      = (count_ff >= CNT_W'(DEPTH));
   assign past_count   = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
   assign read_at_addr = CMP_W'(count_ff) - CMP_W'(pos_ff) - CMP_W'(1);

   // shared compare unit: entry from memory against the search key
   assign hit = (rd_data == val_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lse_pkg::S_IDLE: begin
            if (accept) state_in = lse_pkg::S_EXEC;
         end
         lse_pkg::S_EXEC: begin
            state_in = lse_pkg::S_DONE;
            case (mode_ff)
               lse_pkg::OP_POP: begin
                  if (count_ff > CNT_W'(1)) state_in = lse_pkg::S_TOP_LOAD;
               end
               lse_pkg::OP_SEARCH: begin
                  if (count_ff != '0) state_in = lse_pkg::S_SCAN;
               end
               lse_pkg::OP_READ: begin
                  if (!past_count) state_in = lse_pkg::S_READ;
               end
               default: state_in = lse_pkg::S_DONE;
            endcase
         end
         lse_pkg::S_TOP_LOAD: state_in = lse_pkg::S_DONE;
         lse_pkg::S_READ:     state_in = lse_pkg::S_DONE;
         lse_pkg::S_SCAN: begin
            if (hit || scan_addr_ff == '0) state_in = lse_pkg::S_DONE;
         end
         lse_pkg::S_DONE: begin
            if (out_free) state_in = lse_pkg::S_IDLE;
         end
         default: state_in = lse_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mode_in      = mode_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      dist_in      = dist_ff;
      scan_addr_in = scan_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(count_ff);
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_addr_ff;

      case (state_ff)
         lse_pkg::S_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               val_in    = req_value;
               pos_in    = req_position;
               data_in   = '0;
               status_in = lse_pkg::ST_OK;
               dist_in   = '0;
            end
         end
         lse_pkg::S_EXEC: begin
            case (mode_ff)
               lse_pkg::OP_PUSH: begin
                  if (is_full) begin
                     status_in = lse_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     top_in   = val_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               lse_pkg::OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = lse_pkg::ST_EMPTY;
                  end else begin
                     data_in  = top_ff;
                     count_in = count_ff - CNT_W'(1);
                     // fetch the entry that becomes the new top
                     rd_en    = (count_ff > CNT_W'(1));
                     rd_addr  = ADDR_W'(count_ff - CNT_W'(2));
                  end
               end
               lse_pkg::OP_SEARCH: begin
                  if (count_ff == '0) begin
                     status_in = lse_pkg::ST_NOTFOUND;
                  end else begin
                     rd_en        = 1'b1;
                     rd_addr      = ADDR_W'(count_ff - CNT_W'(1));
                     scan_addr_in = ADDR_W'(count_ff - CNT_W'(1));
                  end
               end
               lse_pkg::OP_READ: begin
                  if (past_count) begin
                     status_in = lse_pkg::ST_RANGE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = ADDR_W'(read_at_addr);
                  end
               end
               lse_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  status_in = lse_pkg::ST_OK;
               end
            endcase
         end
         lse_pkg::S_TOP_LOAD: begin
            top_in = rd_data;
         end
         lse_pkg::S_READ: begin
            data_in = rd_data;
         end
         lse_pkg::S_SCAN: begin
            // compare one entry per cycle while the next read is in flight
            if (hit) begin
               status_in = lse_pkg::ST_OK;
            end else if (scan_addr_ff == '0) begin
               status_in = lse_pkg::ST_NOTFOUND;
               dist_in   = '0;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff - ADDR_W'(1);
               scan_addr_in = scan_addr_ff - ADDR_W'(1);
               dist_in      = dist_ff + ADDR_W'(1);
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lse_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      top_ff       <= top_in;
      data_ff      <= data_in;
      status_ff    <= status_in;
      dist_ff      <= dist_in;
      scan_addr_ff <= scan_addr_in;
   end

   assign req_ready             = (state_ff == lse_pkg::S_IDLE);
   assign result.valid          = (state_ff == lse_pkg::S_DONE);
   assign result.status         = status_ff;
   assign result.match_distance = lse_pkg::DIST_W'(dist_ff);
   assign result_data           = data_ff;
   assign count                 = count_ff;
   assign top_entry             = top_ff;

endmodule

// ----- hdl/lifo_stack_engine.sv -----
`timescale 1ns / 1ps
// Sequencing: each request passes S_EXEC and S_DONE and then loads the response register;
// pop of more than one entry adds S_TOP_LOAD, read-at adds S_READ, and search adds S_SCAN,
// one stored entry per cycle on the read port from the top down, up to DEPTH entries.
// Flow: one request at a time, taken the cycle after the previous result is registered,
// so a new request also waits while S_DONE is held by a stalled response.
// Reset (synchronous, active high) empties the stack and drops any pending response.
module lifo_stack_engine #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   lse_req_if.sink    req_chan,
   lse_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   lse_pkg::seq_result_type result;
   logic [DATA_WIDTH-1:0]   result_data;
   logic [CNT_W-1:0]        count;
   logic [DATA_WIDTH-1:0]   top_entry;
   logic                    out_free;

   logic [63:0]             value_ext;
   logic [DATA_WIDTH-1:0]   value_cut;
   logic [63:0]             data_ext;
   logic [63:0]             top_ext;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]   rd_data;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [lse_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [lse_pkg::VALUE_W-1:0]          rsp_data_ff, rsp_data_in;
   logic [lse_pkg::DIST_W-1:0]           rsp_dist_ff, rsp_dist_in;
   logic [lse_pkg::COUNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                                 rsp_empty_ff, rsp_empty_in;
   logic [lse_pkg::VALUE_W-1:0]          rsp_top_ff, rsp_top_in;

   // cut the request value to the entry width
   assign value_ext = 64'($signed(req_chan.value));
   assign value_cut = value_ext[DATA_WIDTH-1:0];

   lse_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_mode     (lse_pkg::op_type'(req_chan.mode)),
      .req_value    (value_cut),
      .req_position (req_chan.position),
      .out_free     (out_free),
      .result       (result),
      .result_data  (result_data),
      .count        (count),
      .top_entry    (top_entry),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   lse_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sign-extend entries to the response width
   assign data_ext = 64'($signed(result_data));
   assign top_ext  = 64'($signed(top_entry));

   // response register: loads when empty or when the held beat leaves
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_top_in    = rsp_top_ff;
      if (result.valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_data_in   = data_ext[lse_pkg::VALUE_W-1:0];
         rsp_dist_in   = result.match_distance;
         rsp_count_in  = lse_pkg::COUNT_W'(count);
         rsp_empty_in  = (count == '0);
         rsp_top_in    = (count == '0) ? '0 : top_ext[lse_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_top_ff    <= rsp_top_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.data           = rsp_data_ff;
   assign rsp_chan.match_distance = rsp_dist_ff;
   assign rsp_chan.count          = rsp_count_ff;
   assign rsp_chan.is_empty       = rsp_empty_ff;
   assign rsp_chan.top_value      = rsp_top_ff;

endmodule
